// ----- design/scm_pkg.sv -----
// shared types, constants and the sine table function for the crossfade mixer
`timescale 1ns / 1ps

package scm_pkg;

  localparam int unsigned FADE_W           = 24;
  localparam int unsigned OFFSET_W         = 25;
  localparam int unsigned SAMPLE_W         = 16;
  localparam int unsigned GAIN_W           = 17;
  localparam int unsigned VOL_W            = 16;
  localparam int unsigned CFG_DATA_W       = 24;
  localparam int unsigned CFG_INDEX_W      = 2;
  localparam int unsigned CURVE_W          = 2;
  localparam int unsigned DIV_STEPS        = 16;
  localparam int unsigned GAIN_STAGES      = 3;
  localparam int unsigned FRAME_CH         = 2;
  localparam int unsigned MIX_CHANNELS     = 2;
  localparam int unsigned SINE_ENTRIES_DEF = 256;

  localparam logic [GAIN_W-1:0] T_ONE       = 17'h10000;
  localparam logic [VOL_W-1:0]  VOL_RESET   = 16'd16384;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FADE_LENGTH   = 2'd0,
    REG_CURVE_MODE    = 2'd1,
    REG_MASTER_VOLUME = 2'd2
  } reg_idx_e;

  typedef enum logic [CURVE_W-1:0] {
    CURVE_LINEAR   = 2'd0,
    CURVE_EQ_POWER = 2'd1,
    CURVE_SMOOTH   = 2'd2
  } curve_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t [FRAME_CH-1:0] outgoing;
    sample_t [FRAME_CH-1:0] incoming;
  } frame_t;

  // position class of a frame relative to the fade window
  typedef struct packed {
    logic bypass;
    logic t_zero;
    logic t_one;
  } fade_ctl_t;

  typedef struct packed {
    logic              bypass;
    logic [GAIN_W-1:0] t;
  } gain_req_t;

  // sin(x) with x in Q2.30, 9 taylor terms, result in Q1.16 capped at 1.0
  function automatic logic [GAIN_W-1:0] sine_q16(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        r;
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (n % 2 == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    r = (unsigned'(acc) + 64'd8192) >> 14;
    if (r > 64'(T_ONE)) begin
      r = 64'(T_ONE);
    end
    return r[GAIN_W-1:0];
  endfunction

endpackage

// ----- design/stereo_crossfade_mixer_unit.sv -----
// crossfade mixer top level: config registers, stage control and the mix datapath
//
// One stereo frame enters per transfer on the s_axis channel; one mixed frame
// leaves per transfer on the m_axis channel, with the clip flag in tuser.
// Configuration (fade length, curve, master volume) is written on the cfg
// channel, which is always ready; write it only while no frame is in flight.
//
// The pipeline has one capture stage, 16 divider stages for the fade
// position (one quotient bit per stage), one clamp stage, three gain stages,
// then product, sum, volume and round/saturate. Throughput is one frame per
// cycle while the receiver does not stall the output.
//
// Reset empties the pipeline and loads fade length 0, linear curve and unity
// volume. When the receiver stalls, the output holds and the run of full stages
// next to it keeps its frames; stages above the first gap still move, so gaps
// are squeezed out and s_axis_tready drops only when every stage holds a frame.
`timescale 1ns / 1ps

module stereo_crossfade_mixer_unit import scm_pkg::*; #(
  parameter int unsigned SineTableEntries = SINE_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // frame_offset, outgoing_left, outgoing_right, incoming_left, incoming_right
  input  logic [95:0]            s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // mixed_left, mixed_right
  output logic [31:0]            m_axis_tdata,
  // clipped
  output logic                   m_axis_tuser
);

  localparam int unsigned StDiv0 = 1;
  localparam int unsigned StT    = StDiv0 + DIV_STEPS;
  localparam int unsigned StG0   = StT + 1;
  localparam int unsigned StProd = StG0 + GAIN_STAGES;
  localparam int unsigned StAcc  = StProd + 1;
  localparam int unsigned StVol  = StAcc + 1;
  localparam int unsigned StOut  = StVol + 1;
  localparam int unsigned NumSt  = StOut + 1;

  localparam int unsigned ProdW = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned AccW  = ProdW + 1;
  localparam int unsigned VprW  = AccW + VOL_W + 1;
  localparam int unsigned RndW  = VprW - 30;

  // configuration registers
  logic [FADE_W-1:0]  fade_length_q;
  logic [CURVE_W-1:0] curve_mode_q;
  logic [VOL_W-1:0]   master_volume_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_length_q   <= '0;
      curve_mode_q    <= CURVE_LINEAR;
      master_volume_q <= VOL_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FADE_LENGTH:   fade_length_q   <= cfg_data_i[FADE_W-1:0];
        REG_CURVE_MODE:    curve_mode_q    <= cfg_data_i[CURVE_W-1:0];
        REG_MASTER_VOLUME: master_volume_q <= cfg_data_i[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage control: a stage loads when it is empty or the next one moves
  logic [NumSt-1:0] valid_q;
  logic [NumSt-1:0] valid_d;
  logic [NumSt-1:0] en;

  for (genvar k = 0; k < NumSt; k++) begin : g_en
    assign en[k] = m_axis_tready | ~(&valid_q[NumSt-1:k]);
  end

  always_comb begin
    for (int k = 0; k < NumSt; k++) begin
      if (en[k]) begin
        valid_d[k] = (k == 0) ? s_axis_tvalid : valid_q[(k == 0) ? 0 : k - 1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[StOut];

  // input unpacking and position class
  logic signed [OFFSET_W-1:0] in_offset;
  frame_t                     in_frame;
  fade_ctl_t                  in_ctl;

  always_comb begin
    in_offset            = s_axis_tdata[24:0];
    in_frame.outgoing[0] = s_axis_tdata[40:25];
    in_frame.outgoing[1] = s_axis_tdata[56:41];
    in_frame.incoming[0] = s_axis_tdata[72:57];
    in_frame.incoming[1] = s_axis_tdata[88:73];
    in_ctl.bypass        = (fade_length_q == '0);
    in_ctl.t_zero        = in_offset[OFFSET_W-1] | (in_offset == '0);
    in_ctl.t_one         = ~in_ctl.t_zero & (in_offset[FADE_W-1:0] >= fade_length_q);
  end

  fade_ctl_t         ctl_q [StT];
  frame_t            smp_q [StProd];
  logic [FADE_W-1:0] num_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ctl_q[0] <= in_ctl;
      smp_q[0] <= in_frame;
      num_q    <= in_offset[FADE_W-1:0];
    end
    for (int k = 1; k < StT; k++) begin
      if (en[k]) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
    for (int k = 1; k < StProd; k++) begin
      if (en[k]) begin
        smp_q[k] <= smp_q[k-1];
      end
    end
  end

  // fade position t = offset * 65536 / fade_length
  logic [DIV_STEPS-1:0] quo;

  scm_divider #(
    .Steps (DIV_STEPS)
  ) u_divider (
    .clk_i (clk_i),
    .en_i  (en[StDiv0 +: DIV_STEPS]),
    .num_i (num_q),
    .den_i (fade_length_q),
    .quo_o (quo)
  );

  fade_ctl_t         ctl_div;
  logic [GAIN_W-1:0] t_d;
  gain_req_t         greq_q;

  always_comb begin
    ctl_div = ctl_q[StT-1];
    if (ctl_div.bypass || ctl_div.t_zero) begin
      t_d = '0;
    end else if (ctl_div.t_one) begin
      t_d = T_ONE;
    end else begin
      t_d = {1'b0, quo};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StT]) begin
      greq_q.bypass <= ctl_div.bypass;
      greq_q.t      <= t_d;
    end
  end

  logic [GAIN_W-1:0] gout;
  logic [GAIN_W-1:0] gin;

  scm_gain #(
    .SineTableEntries (SineTableEntries)
  ) u_gain (
    .clk_i        (clk_i),
    .en_i         (en[StG0 +: GAIN_STAGES]),
    .curve_mode_i (curve_mode_q),
    .req_i        (greq_q),
    .gout_o       (gout),
    .gin_o        (gin)
  );

  // mix, volume, round and saturate per channel
  logic signed [ProdW-1:0]    pout_q [FRAME_CH];
  logic signed [ProdW-1:0]    pin_q  [FRAME_CH];
  logic signed [AccW-1:0]     acc_q  [FRAME_CH];
  logic signed [VprW-1:0]     vpr_q  [FRAME_CH];
  logic signed [SAMPLE_W-1:0] out_q  [FRAME_CH];
  logic                       clip_q;

  logic signed [ProdW-1:0]    gout_s;
  logic signed [ProdW-1:0]    gin_s;
  logic signed [VprW-1:0]     vol_s;
  logic signed [VprW-1:0]     vrnd   [FRAME_CH];
  logic signed [RndW-1:0]     rnd    [FRAME_CH];
  logic signed [SAMPLE_W-1:0] out_d  [FRAME_CH];
  logic                       clip_d;

  always_comb begin
    gout_s = ProdW'(signed'({1'b0, gout}));
    gin_s  = ProdW'(signed'({1'b0, gin}));
    vol_s  = VprW'(signed'({1'b0, master_volume_q}));
    clip_d = 1'b0;
    for (int c = 0; c < FRAME_CH; c++) begin
      vrnd[c]  = vpr_q[c] + VprW'(signed'(64'sd536870912));
      rnd[c]   = vrnd[c][VprW-1:30];
      out_d[c] = '0;
      if (c < MIX_CHANNELS) begin
        if (rnd[c] > RndW'(signed'(32'sd32767))) begin
          out_d[c] = 16'sh7fff;
          clip_d   = 1'b1;
        end else if (rnd[c] < RndW'(signed'(-32'sd32768))) begin
          out_d[c] = -16'sh8000;
          clip_d   = 1'b1;
        end else begin
          out_d[c] = rnd[c][SAMPLE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < FRAME_CH; c++) begin
      if (en[StProd]) begin
        pout_q[c] <= ProdW'(smp_q[StProd-1].outgoing[c]) * gout_s;
        pin_q[c]  <= ProdW'(smp_q[StProd-1].incoming[c]) * gin_s;
      end
      if (en[StAcc]) begin
        acc_q[c] <= AccW'(pout_q[c]) + AccW'(pin_q[c]);
      end
      if (en[StVol]) begin
        vpr_q[c] <= VprW'(acc_q[c]) * vol_s;
      end
      if (en[StOut]) begin
        out_q[c] <= out_d[c];
      end
    end
    if (en[StOut]) begin
      clip_q <= clip_d;
    end
  end

  assign m_axis_tdata = {out_q[1], out_q[0]};
  assign m_axis_tuser = clip_q;

endmodule

// ----- design/scm_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, for the fade position
`timescale 1ns / 1ps

module scm_divider import scm_pkg::*; #(
  parameter int unsigned Steps = DIV_STEPS
) (
  input  logic              clk_i,
  input  logic [Steps-1:0]  en_i,
  input  logic [FADE_W-1:0] num_i,
  input  logic [FADE_W-1:0] den_i,
  output logic [Steps-1:0]  quo_o
);

  logic [FADE_W-1:0] rem_q [Steps];
  logic [Steps-1:0]  quo_q [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic [FADE_W-1:0] rem_prev;
    logic [Steps-1:0]  quo_prev;
    logic [FADE_W:0]   rem_shl;
    logic              take;

    if (j == 0) begin : g_first
      assign rem_prev = num_i;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_q[j-1];
      assign quo_prev = quo_q[j-1];
    end

    // remainder stays below the divisor, so the shifted value fits one extra bit
    assign rem_shl = {rem_prev, 1'b0};
    assign take    = rem_shl >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= take ? FADE_W'(rem_shl - {1'b0, den_i}) : rem_shl[FADE_W-1:0];
        quo_q[j] <= {quo_prev[Steps-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[Steps-1];

endmodule

// ----- design/scm_gain.sv -----
// gain curves: linear, quarter-wave sine lookup and smoothstep, three stages
`timescale 1ns / 1ps

module scm_gain import scm_pkg::*; #(
  parameter int unsigned SineTableEntries = SINE_ENTRIES_DEF
) (
  input  logic                   clk_i,
  input  logic [GAIN_STAGES-1:0] en_i,
  input  logic [CURVE_W-1:0]     curve_mode_i,
  input  gain_req_t              req_i,
  output logic [GAIN_W-1:0]      gout_o,
  output logic [GAIN_W-1:0]      gin_o
);

  localparam int unsigned IdxW = $clog2(SineTableEntries + 1);
  localparam int unsigned PosW = GAIN_W + IdxW;
  localparam int unsigned SmW  = GAIN_W + 1;

  logic [GAIN_W-1:0] sine_tab [SineTableEntries+1];

  for (genvar k = 0; k <= SineTableEntries; k++) begin : g_tab
    localparam logic [63:0] XQ30 = (64'(k) * HALF_PI_Q30) / SineTableEntries;
    assign sine_tab[k] = sine_q16(XQ30);
  end

  // stage 0: table index and t squared
  logic [PosW-1:0]     pos;
  logic [PosW-16-1:0]  idx_wide;
  logic [IdxW-1:0]     idx_d;
  logic [2*GAIN_W-1:0] tsq;

  logic              byp_g0_q;
  logic [GAIN_W-1:0] t_g0_q;
  logic [IdxW-1:0]   idx_q;
  logic [GAIN_W-1:0] t2_q;

  always_comb begin
    pos      = PosW'(req_i.t) * PosW'(SineTableEntries) + PosW'(32768);
    idx_wide = pos[PosW-1:16];
    if (idx_wide > (PosW - 16)'(SineTableEntries)) begin
      idx_d = IdxW'(SineTableEntries);
    end else begin
      idx_d = idx_wide[IdxW-1:0];
    end
    tsq = (2 * GAIN_W)'(req_i.t) * (2 * GAIN_W)'(req_i.t);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      byp_g0_q <= req_i.bypass;
      t_g0_q   <= req_i.t;
      idx_q    <= idx_d;
      t2_q     <= tsq[GAIN_W+15:16];
    end
  end

  // stage 1: sine reads and the smoothstep product
  logic [SmW-1:0]          sm_fac;
  logic [GAIN_W+SmW-1:0]   sm_prod;
  logic [IdxW-1:0]         idx_rev;

  logic              byp_g1_q;
  logic [GAIN_W-1:0] t_g1_q;
  logic [GAIN_W-1:0] sin_in_q;
  logic [GAIN_W-1:0] sin_out_q;
  logic [SmW:0]      sraw_q;

  always_comb begin
    sm_fac  = SmW'(196608) - {t_g0_q, 1'b0};
    sm_prod = (GAIN_W + SmW)'(t2_q) * (GAIN_W + SmW)'(sm_fac);
    idx_rev = IdxW'(SineTableEntries) - idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      byp_g1_q  <= byp_g0_q;
      t_g1_q    <= t_g0_q;
      sin_in_q  <= sine_tab[idx_q];
      sin_out_q <= sine_tab[idx_rev];
      sraw_q    <= sm_prod[GAIN_W+SmW-1:16];
    end
  end

  // stage 2: pick the pair of gains
  logic [GAIN_W-1:0] s_sat;
  logic [GAIN_W-1:0] gout_d;
  logic [GAIN_W-1:0] gin_d;
  logic [GAIN_W-1:0] gout_q;
  logic [GAIN_W-1:0] gin_q;

  always_comb begin
    s_sat = (sraw_q > (SmW + 1)'(T_ONE)) ? T_ONE : sraw_q[GAIN_W-1:0];
    if (byp_g1_q) begin
      gout_d = T_ONE;
      gin_d  = '0;
    end else begin
      case (curve_mode_i)
        CURVE_EQ_POWER: begin
          gout_d = sin_out_q;
          gin_d  = sin_in_q;
        end
        CURVE_SMOOTH: begin
          gout_d = T_ONE - s_sat;
          gin_d  = s_sat;
        end
        default: begin
          gout_d = T_ONE - t_g1_q;
          gin_d  = t_g1_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      gout_q <= gout_d;
      gin_q  <= gin_d;
    end
  end

  assign gout_o = gout_q;
  assign gin_o  = gin_q;

endmodule

// ----- design/scm_checker.sv -----
// port-level checks for the crossfade mixer, bound to the top level
`timescale 1ns / 1ps

module scm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output transfer changed");

  // clip flag only comes with a saturated channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[15:0] == 16'h7fff || m_axis_tdata[15:0] == 16'h8000 ||
      m_axis_tdata[31:16] == 16'h7fff || m_axis_tdata[31:16] == 16'h8000)
    else $error("clip flag without a saturated sample");

  // input side never blocks while the output drains or is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready || !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with a free pipeline");

  // pipeline is empty once reset has been seen at an edge
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind stereo_crossfade_mixer_unit scm_checker u_checker (.*);
